// ===== hw/rtl/rvb_pkg.sv =====
// ----------------------------------------------------------------------------
// rvb_pkg: shared types and constants for the RGB vibrance boost
// Word layouts, configuration register indexes and the fixed-point constants.
// ----------------------------------------------------------------------------
package rvb_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned AMOUNT_W = 10;
    // k = 256 + boost, boost at most 1023, so 11 bits hold it.
    localparam int unsigned K_W      = 11;
    // amount * (255 - sat) fits in 18 bits.
    localparam int unsigned PROD_W   = 18;
    localparam int unsigned CFG_W    = AMOUNT_W;
    // Register stages between an accepted word and its result.
    localparam int unsigned PIPE_STAGES = 5;

    localparam logic [7:0] LUMA_R   = 8'd54;
    localparam logic [7:0] LUMA_G   = 8'd183;
    localparam logic [7:0] LUMA_B   = 8'd19;
    localparam logic [7:0] FULL_SAT = 8'd255;

    typedef enum logic [0:0] {
        CFG_BOOST_AMOUNT = 1'b0,
        CFG_BLUE_FIRST   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] pix_byte0;
        logic [BYTE_W-1:0] pix_byte1;
        logic [BYTE_W-1:0] pix_byte2;
        logic [BYTE_W-1:0] pix_byte3;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte0;
        logic [BYTE_W-1:0] out_byte1;
        logic [BYTE_W-1:0] out_byte2;
        logic [BYTE_W-1:0] out_byte3;
    } t_pix_out;

endpackage

// ===== hw/rtl/rvb_chan.sv =====
// ----------------------------------------------------------------------------
// rvb_chan: one color channel of the vibrance boost
// Two register stages: scale the distance from luma by k, then shift, add
// luma back, clamp, and pick the original byte for passthrough pixels.
// ----------------------------------------------------------------------------
module rvb_chan (
    input  logic                         i_clk,
    input  logic [rvb_pkg::BYTE_W-1:0]   i_chan,
    input  logic [rvb_pkg::BYTE_W-1:0]   i_luma,
    input  logic [rvb_pkg::K_W-1:0]      i_k,
    input  logic                         i_pass,
    output logic [rvb_pkg::BYTE_W-1:0]   o_chan
);

    logic signed [8:0]                 w_diff;
    logic signed [11:0]                w_k;
    logic signed [20:0]                n_prod;
    logic signed [20:0]                r_prod;
    logic [rvb_pkg::BYTE_W-1:0]        r_chan;
    logic [rvb_pkg::BYTE_W-1:0]        r_luma;
    logic                              r_pass;
    logic signed [13:0]                w_sum;
    logic [rvb_pkg::BYTE_W-1:0]        n_out;
    logic [rvb_pkg::BYTE_W-1:0]        r_out;

    always_comb begin
        w_diff = $signed({1'b0, i_chan}) - $signed({1'b0, i_luma});
        w_k    = $signed({1'b0, i_k});
        n_prod = 21'(w_diff) * 21'(w_k);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_chan <= i_chan;
        r_luma <= i_luma;
        r_pass <= i_pass;
    end

    // The arithmetic shift rounds toward minus infinity.
    always_comb begin
        w_sum = 14'(r_prod >>> 8) + $signed({6'b0, r_luma});
        if (r_pass) begin
            n_out = r_chan;
        end else if (w_sum < 14'sd0) begin
            n_out = '0;
        end else if (w_sum > 14'sd255) begin
            n_out = 8'd255;
        end else begin
            n_out = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_chan = r_out;

endmodule

// ===== hw/rtl/rgb_vibrance_boost.sv =====
// ----------------------------------------------------------------------------
// rgb_vibrance_boost: saturation boost weighted toward muted colors
// An accepted word passes through the five pipeline stages and appears on
// o_pix with o_done. Throughput: one word per clock, o_busy is always low
// and the receiver cannot stall.
// Reset clears the valid pipeline and both configuration registers.
// ----------------------------------------------------------------------------
module rgb_vibrance_boost (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  rvb_pkg::t_pix_in              i_pix,
    output logic                          o_done,
    output rvb_pkg::t_pix_out             o_pix,
    input  logic                          i_cfg_we,
    input  rvb_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [rvb_pkg::CFG_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [rvb_pkg::AMOUNT_W-1:0] r_amount;
    logic                         r_blue_first;

    // One valid bit per pipeline stage.
    logic [rvb_pkg::PIPE_STAGES-1:0] r_vld;
    logic [rvb_pkg::PIPE_STAGES-1:0] n_vld;

    // Stage 1: saturation, luma and the passthrough decision.
    logic [7:0]        w_r, w_b, w_max, w_min, w_sat;
    logic [15:0]       w_luma_sum;
    rvb_pkg::t_pix_in  r_s1_pix;
    logic [7:0]        r_s1_luma;
    logic [7:0]        r_s1_inv;
    logic              r_s1_pass;

    // Stage 2: amount times the unsaturated share.
    rvb_pkg::t_pix_in             r_s2_pix;
    logic [7:0]                   r_s2_luma;
    logic                         r_s2_pass;
    logic [rvb_pkg::PROD_W-1:0]   r_s2_prod;

    // Stage 3: division by 255 and the gain k.
    logic [rvb_pkg::PROD_W:0]     w_est_sum;
    logic [rvb_pkg::K_W-1:0]      w_est;
    logic [rvb_pkg::PROD_W:0]     w_est255;
    logic [rvb_pkg::PROD_W:0]     w_rem;
    logic [rvb_pkg::K_W-1:0]      w_boost;
    rvb_pkg::t_pix_in             r_s3_pix;
    logic [7:0]                   r_s3_luma;
    logic                         r_s3_pass;
    logic [rvb_pkg::K_W-1:0]      r_s3_k;

    // The fourth byte rides alongside the channel units.
    logic [7:0] r_s4_a;
    logic [7:0] r_s5_a;
    logic [7:0] w_out0, w_out1, w_out2;

    // Configuration writes land the same edge they are presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount     <= '0;
            r_blue_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rvb_pkg::CFG_BOOST_AMOUNT: r_amount     <= i_cfg_data;
                rvb_pkg::CFG_BLUE_FIRST:   r_blue_first <= i_cfg_data[0];
                default:                   r_amount     <= r_amount;
            endcase
        end
    end

    // Nothing ever holds the pipeline back, so every start is taken.
    assign o_busy = 1'b0;

    always_comb begin
        n_vld = {r_vld[rvb_pkg::PIPE_STAGES-2:0], i_start & ~o_busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 1. The channels are adjusted in their byte positions, so only the
    // luma weights need to know which outer byte is red.
    always_comb begin
        w_r   = r_blue_first ? i_pix.pix_byte2 : i_pix.pix_byte0;
        w_b   = r_blue_first ? i_pix.pix_byte0 : i_pix.pix_byte2;
        w_max = (w_r > i_pix.pix_byte1) ? w_r : i_pix.pix_byte1;
        w_min = (w_r < i_pix.pix_byte1) ? w_r : i_pix.pix_byte1;
        if (w_b > w_max) begin
            w_max = w_b;
        end
        if (w_b < w_min) begin
            w_min = w_b;
        end
        w_sat      = w_max - w_min;
        w_luma_sum = 16'(rvb_pkg::LUMA_R * w_r) + 16'(rvb_pkg::LUMA_G * i_pix.pix_byte1)
                   + 16'(rvb_pkg::LUMA_B * w_b);
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_pix;
        r_s1_luma <= w_luma_sum[15:8];
        r_s1_inv  <= rvb_pkg::FULL_SAT - w_sat;
        // Zero amount, a grey pixel and a fully saturated pixel pass unchanged.
        r_s1_pass <= (r_amount == '0) || (w_sat == 8'd0) || (w_sat == rvb_pkg::FULL_SAT);
    end

    // Stage 2.
    always_ff @(posedge i_clk) begin
        r_s2_pix  <= r_s1_pix;
        r_s2_luma <= r_s1_luma;
        r_s2_pass <= r_s1_pass;
        r_s2_prod <= rvb_pkg::PROD_W'(r_amount * r_s1_inv);
    end

    // Stage 3. (p + p/256)/256 never overshoots p/255 and falls short by at
    // most one, so the remainder against 255 settles the quotient.
    always_comb begin
        w_est_sum = {1'b0, r_s2_prod} + (rvb_pkg::PROD_W + 1)'(r_s2_prod >> 8);
        w_est     = rvb_pkg::K_W'(w_est_sum >> 8);
        w_est255  = ((rvb_pkg::PROD_W + 1)'(w_est) << 8)
                  - (rvb_pkg::PROD_W + 1)'(w_est);
        w_rem     = {1'b0, r_s2_prod} - w_est255;
        w_boost   = w_est + rvb_pkg::K_W'(w_rem >= 19'd255)
                  + rvb_pkg::K_W'(w_rem >= 19'd510);
    end

    always_ff @(posedge i_clk) begin
        r_s3_pix  <= r_s2_pix;
        r_s3_luma <= r_s2_luma;
        r_s3_pass <= r_s2_pass;
        r_s3_k    <= rvb_pkg::K_W'(256) + w_boost;
    end

    // Stages 4 and 5, one unit per color byte.
    rvb_chan u_chan0 (
        .i_clk  (i_clk),
        .i_chan (r_s3_pix.pix_byte0),
        .i_luma (r_s3_luma),
        .i_k    (r_s3_k),
        .i_pass (r_s3_pass),
        .o_chan (w_out0)
    );

    rvb_chan u_chan1 (
        .i_clk  (i_clk),
        .i_chan (r_s3_pix.pix_byte1),
        .i_luma (r_s3_luma),
        .i_k    (r_s3_k),
        .i_pass (r_s3_pass),
        .o_chan (w_out1)
    );

    rvb_chan u_chan2 (
        .i_clk  (i_clk),
        .i_chan (r_s3_pix.pix_byte2),
        .i_luma (r_s3_luma),
        .i_k    (r_s3_k),
        .i_pass (r_s3_pass),
        .o_chan (w_out2)
    );

    always_ff @(posedge i_clk) begin
        r_s4_a <= r_s3_pix.pix_byte3;
        r_s5_a <= r_s4_a;
    end

    assign o_done          = r_vld[rvb_pkg::PIPE_STAGES-1];
    assign o_pix.out_byte0 = w_out0;
    assign o_pix.out_byte1 = w_out1;
    assign o_pix.out_byte2 = w_out2;
    assign o_pix.out_byte3 = r_s5_a;

    // Every accepted word raises o_done once it has passed all pipeline stages.
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(rvb_pkg::PIPE_STAGES) o_done)
        else $error("accepted word did not complete after five cycles");

    // The fourth byte leaves with the word it entered with.
    a_alpha_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pix.out_byte3 == $past(i_pix.pix_byte3, rvb_pkg::PIPE_STAGES)))
        else $error("fourth byte lost its alignment with the word");

    // The quotient estimate needs at most one correction.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (w_rem < 19'd510))
        else $error("division remainder out of range");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB vibrance boost
// Pixel words are sent in random bursts under several boost strengths and
// both byte orders. Each accepted word is predicted in the bench and every
// done word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The pipeline is five stages deep, so a short pad after the last word
    // covers anything still in flight.
    localparam int unsigned LATENCY_PAD    = 10;
    // No correct run ever goes this many cycles without an accept or a done.
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic                          o_busy;
    rvb_pkg::t_pix_in              i_pix = '0;
    logic                          o_done;
    rvb_pkg::t_pix_out             o_pix;
    logic                          i_cfg_we = 1'b0;
    rvb_pkg::t_cfg_idx             i_cfg_idx = rvb_pkg::CFG_BOOST_AMOUNT;
    logic [rvb_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // Bench copy of the two configuration registers, at their reset values.
    logic [rvb_pkg::AMOUNT_W-1:0]  boost_amount_q = '0;
    logic                          blue_first_q = 1'b0;

    // Predicted output words, oldest first.
    rvb_pkg::t_pix_out             pending_pixels[$];
    rvb_pkg::t_pix_out             oldest_pixel;
    int unsigned                   error_count = 0;
    int unsigned                   quiet_cycles = 0;

    rgb_vibrance_boost u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_pix      (i_pix),
        .o_done     (o_done),
        .o_pix      (o_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Pushes one channel away from the luma by k/256. The product can be
    // negative, and the arithmetic shift on a signed int floors it, which is
    // what the hardware does. The sum is then clamped to a byte.
    function automatic logic [rvb_pkg::BYTE_W-1:0] stretch_channel(int chan, int luma,
                                                                   int k);
        int v;
        v = luma + (((chan - luma) * k) >>> 8);
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v[rvb_pkg::BYTE_W-1:0];
    endfunction

    // Computes the boosted word for one input word under the given settings.
    function automatic rvb_pkg::t_pix_out boosted_pixel(rvb_pkg::t_pix_in p,
                                                        logic [rvb_pkg::AMOUNT_W-1:0] amount,
                                                        logic blue_first);
        rvb_pkg::t_pix_out res;
        logic [7:0]  red, grn, blu, hi, lo, sat;
        int          luma, boost, k, amt;
        logic [7:0]  new_red, new_grn, new_blu;
        red = blue_first ? p.pix_byte2 : p.pix_byte0;
        grn = p.pix_byte1;
        blu = blue_first ? p.pix_byte0 : p.pix_byte2;
        hi = (red > grn) ? red : grn;
        lo = (red < grn) ? red : grn;
        if (blu > hi) begin
            hi = blu;
        end
        if (blu < lo) begin
            lo = blu;
        end
        sat = hi - lo;
        res.out_byte0 = p.pix_byte0;
        res.out_byte1 = p.pix_byte1;
        res.out_byte2 = p.pix_byte2;
        res.out_byte3 = p.pix_byte3;
        // A zero amount, a grey pixel and a fully saturated pixel all leave
        // the word untouched.
        if (amount != '0 && sat != 8'd0 && sat != rvb_pkg::FULL_SAT) begin
            amt = int'(amount);
            luma = (54 * int'(red) + 183 * int'(grn) + 19 * int'(blu)) >>> 8;
            boost = (amt * (255 - int'(sat))) / 255;
            k = 256 + boost;
            new_red = stretch_channel(int'(red), luma, k);
            new_grn = stretch_channel(int'(grn), luma, k);
            new_blu = stretch_channel(int'(blu), luma, k);
            res.out_byte0 = blue_first ? new_blu : new_red;
            res.out_byte1 = new_grn;
            res.out_byte2 = blue_first ? new_red : new_blu;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("tb_top: mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // The receiver cannot hold results off, so every cycle with o_done high
    // carries a word that is taken at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("done word %08h with nothing pending", o_pix));
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                if (o_pix.out_byte0 !== oldest_pixel.out_byte0) begin
                    report_mismatch($sformatf("out_byte0 got %02h, expected %02h",
                                              o_pix.out_byte0, oldest_pixel.out_byte0));
                end
                if (o_pix.out_byte1 !== oldest_pixel.out_byte1) begin
                    report_mismatch($sformatf("out_byte1 got %02h, expected %02h",
                                              o_pix.out_byte1, oldest_pixel.out_byte1));
                end
                if (o_pix.out_byte2 !== oldest_pixel.out_byte2) begin
                    report_mismatch($sformatf("out_byte2 got %02h, expected %02h",
                                              o_pix.out_byte2, oldest_pixel.out_byte2));
                end
                if (o_pix.out_byte3 !== oldest_pixel.out_byte3) begin
                    report_mismatch($sformatf("out_byte3 got %02h, expected %02h",
                                              o_pix.out_byte3, oldest_pixel.out_byte3));
                end
            end
        end
    end

    // The watchdog restarts whenever a word goes in or comes out. A long run
    // of quiet cycles means the block has hung or lost a word.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Presents one word and holds it until it is taken. Start is left high,
    // so back-to-back calls stream one word per clock; idle_for with a nonzero count lowers it.
    task automatic send_pixel(rvb_pkg::t_pix_in p);
        i_start <= 1'b1;
        i_pix   <= p;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        pending_pixels.push_back(boosted_pixel(p, boost_amount_q, blue_first_q));
    endtask

    task automatic idle_for(int unsigned cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every predicted word has come back,
    // then lets the pipeline run empty for good measure.
    task automatic drain_pipeline();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(rvb_pkg::t_cfg_idx idx, logic [rvb_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == rvb_pkg::CFG_BOOST_AMOUNT) begin
            boost_amount_q = data[rvb_pkg::AMOUNT_W-1:0];
        end else begin
            blue_first_q = data[0];
        end
    endtask

    // Registers only change with the pipeline empty.
    task automatic apply_setting(logic [rvb_pkg::AMOUNT_W-1:0] amount, logic blue_first);
        drain_pipeline();
        write_reg(rvb_pkg::CFG_BOOST_AMOUNT, rvb_pkg::CFG_W'(amount));
        write_reg(rvb_pkg::CFG_BLUE_FIRST, rvb_pkg::CFG_W'(blue_first));
    endtask

    function automatic rvb_pkg::t_pix_in make_pixel(logic [7:0] b0, logic [7:0] b1,
                                                    logic [7:0] b2, logic [7:0] b3);
        rvb_pkg::t_pix_in p;
        p.pix_byte0 = b0;
        p.pix_byte1 = b1;
        p.pix_byte2 = b2;
        p.pix_byte3 = b3;
        return p;
    endfunction

    // Mostly arbitrary colors, with a share of grey pixels and of pixels
    // whose channels span the full 0..255 range, so the passthrough paths
    // keep turning up among the boosted ones.
    function automatic rvb_pkg::t_pix_in random_pixel();
        logic [7:0]  chan[3];
        int unsigned kind, lo_pos, hi_pos;
        kind = $urandom_range(0, 7);
        chan[0] = 8'($urandom_range(0, 255));
        chan[1] = 8'($urandom_range(0, 255));
        chan[2] = 8'($urandom_range(0, 255));
        if (kind == 0) begin
            chan[1] = chan[0];
            chan[2] = chan[0];
        end else if (kind == 1) begin
            lo_pos = $urandom_range(0, 2);
            hi_pos = (lo_pos + 1 + $urandom_range(0, 1)) % 3;
            chan[lo_pos] = 8'd0;
            chan[hi_pos] = 8'd255;
        end else if (kind == 2) begin
            // Near-grey colors get the strongest boost.
            chan[1] = chan[0] + 8'($urandom_range(0, 6)) - 8'd3;
            chan[2] = chan[0] + 8'($urandom_range(0, 6)) - 8'd3;
        end
        return make_pixel(chan[0], chan[1], chan[2], 8'($urandom_range(0, 255)));
    endfunction

    // Sends a number of random words in bursts. About a quarter of the gaps
    // are zero, so long stretches run at full rate.
    task automatic send_random_bursts(int unsigned count);
        int unsigned sent, burst, i;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (i = 0; i < burst && sent < count; i++) begin
                send_pixel(random_pixel());
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                idle_for(0);
            end else begin
                idle_for($urandom_range(1, 12));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight out of reset the amount is zero, so every word passes.
    task automatic test_reset_passthrough();
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h80, 8'h5A));
        send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'hFF));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Grey and fully saturated pixels must pass even with a strong boost.
    task automatic test_grey_and_full_sat();
        apply_setting(10'd512, 1'b0);
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h11));
        send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 8'h22));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h33));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'h44));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h80, 8'h55));
        send_pixel(make_pixel(8'hC8, 8'h00, 8'hFF, 8'h66));
    endtask

    // The largest amount drives most channels into the clamps; the smallest
    // barely moves them. Both byte orders are covered.
    task automatic test_amount_extremes();
        apply_setting(10'd1023, 1'b1);
        send_pixel(make_pixel(8'h00, 8'h80, 8'hFE, 8'h00));
        send_pixel(make_pixel(8'hFF, 8'h01, 8'h80, 8'hFF));
        send_pixel(make_pixel(8'h0A, 8'h14, 8'h1E, 8'hA5));
        send_pixel(make_pixel(8'h01, 8'h00, 8'h00, 8'h5A));
        send_pixel(make_pixel(8'hFE, 8'hFF, 8'hFF, 8'h01));
        apply_setting(10'd1, 1'b0);
        send_pixel(make_pixel(8'h00, 8'h80, 8'hFE, 8'h80));
        send_pixel(make_pixel(8'h7F, 8'h80, 8'h81, 8'h7F));
        send_pixel(make_pixel(8'h01, 8'h00, 8'h00, 8'hFE));
        apply_setting(10'd513, 1'b0);
        send_pixel(make_pixel(8'h40, 8'h60, 8'h80, 8'hC3));
        send_pixel(make_pixel(8'hFF, 8'hF0, 8'hE0, 8'h3C));
    endtask

    // Random words under a spread of settings. Each setting change first
    // waits for every pending word, which also exercises the full drain.
    task automatic test_random_sweep();
        logic [rvb_pkg::AMOUNT_W-1:0] amounts[8];
        logic                         orders[8];
        int unsigned                  i;
        amounts = '{10'd512, 10'd1023, 10'd1, 10'd256, 10'd0, 10'd768,
                    10'd0, 10'd0};
        orders  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        amounts[6] = rvb_pkg::AMOUNT_W'($urandom_range(1, 1023));
        amounts[7] = rvb_pkg::AMOUNT_W'($urandom_range(1, 512));
        for (i = 0; i < 8; i++) begin
            apply_setting(amounts[i], orders[i]);
            send_random_bursts(140);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_passthrough();
        test_grey_and_full_sat();
        test_amount_extremes();
        test_random_sweep();
        drain_pipeline();
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rvb_pkg.sv
hw/rtl/rvb_chan.sv
hw/rtl/rgb_vibrance_boost.sv
tb/tb_top.sv
